>>> src/stepper_half_step_move_macros.svh
// ----------------------------------------------------------------------------
// stepper half-step move: assertion macros
// shared property forms used by the top level checks
// ----------------------------------------------------------------------------
`ifndef STEPPER_HALF_STEP_MOVE_MACROS_SVH
`define STEPPER_HALF_STEP_MOVE_MACROS_SVH

// same-cycle implication, quiet during reset
`define SHSM_ASSERT_IMPLIES(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define SHSM_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

>>> src/shsm_pkg.sv
// ----------------------------------------------------------------------------
// shsm_pkg
// widths, constants, codes and the phase to coil table of the half-step mover
// ----------------------------------------------------------------------------
`default_nettype none

package shsm_pkg;

   // field widths
   localparam int unsigned SPR_W   = 11;
   localparam int unsigned DWELL_W = 16;
   localparam int unsigned DEG_W   = 16;
   localparam int unsigned COIL_W  = 4;
   localparam int unsigned PHASE_W = 3;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 16;

   // product of magnitude and steps per revolution
   localparam int unsigned PROD_W = DEG_W + SPR_W;
   // remaining angle-times-revolution account, one step per STEP_DIV
   localparam int unsigned ACC_W  = 26;

   localparam int unsigned STEP_DIV  = 360;
   localparam int unsigned STEPS_MAX = 131071;

   localparam logic [PROD_W-1:0] PROD_ONE_STEP = PROD_W'(STEP_DIV);
   localparam logic [PROD_W-1:0] PROD_SAT_AT   = PROD_W'((STEPS_MAX + 1) * STEP_DIV);
   localparam logic [ACC_W-1:0]  ACC_SAT       = ACC_W'(STEPS_MAX * STEP_DIV);
   localparam logic [ACC_W-1:0]  ACC_ONE_STEP  = ACC_W'(STEP_DIV);
   localparam logic [ACC_W-1:0]  ACC_TWO_STEPS = ACC_W'(2 * STEP_DIV);

   // register reset values
   localparam logic [SPR_W-1:0]   SPR_RESET   = SPR_W'(400);
   localparam logic [DWELL_W-1:0] DWELL_RESET = DWELL_W'(625);

   // phases at the start of a move
   localparam logic [PHASE_W-1:0] PHASE_FWD_START = 3'd0;
   localparam logic [PHASE_W-1:0] PHASE_REV_START = 3'd7;

   localparam logic [COIL_W-1:0] COILS_OFF = 4'h0;

   // item operation codes
   typedef enum logic {
      OP_MOVE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SPR   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DWELL = 1'b1;

   // live configuration handed to the core
   typedef struct packed {
      logic [SPR_W-1:0]   steps_per_rev;
      logic [DWELL_W-1:0] dwell_ticks;
   } cfg_type;

   // result of one item
   typedef struct packed {
      logic [COIL_W-1:0] coil_drive;
      logic              busy;
      logic              rejected;
   } result_type;

   // eight-phase half-step coil pattern
   function automatic logic [COIL_W-1:0] coil_of_phase(input logic [PHASE_W-1:0] phase);
      logic [COIL_W-1:0] coils;
      case (phase)
         3'd0:    coils = 4'h1;
         3'd1:    coils = 4'h9;
         3'd2:    coils = 4'h8;
         3'd3:    coils = 4'hC;
         3'd4:    coils = 4'h4;
         3'd5:    coils = 4'h6;
         3'd6:    coils = 4'h2;
         3'd7:    coils = 4'h3;
         default: coils = 4'h0;
      endcase
      return coils;
   endfunction

endpackage

`default_nettype wire

>>> src/shsm_csr.sv
// ----------------------------------------------------------------------------
// shsm_csr
// configuration registers: steps per revolution and dwell ticks
// ----------------------------------------------------------------------------
`default_nettype none

module shsm_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   input  wire logic [shsm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [shsm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output shsm_pkg::cfg_type                      cfg
);

   logic [shsm_pkg::SPR_W-1:0]   spr_ff;
   logic [shsm_pkg::DWELL_W-1:0] dwell_ff;

   // register write on each beat
   always_ff @(posedge clock) begin
      if (reset) begin
         spr_ff   <= shsm_pkg::SPR_RESET;
         dwell_ff <= shsm_pkg::DWELL_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            shsm_pkg::CSR_SPR:   spr_ff   <= csr_wdata[shsm_pkg::SPR_W-1:0];
            shsm_pkg::CSR_DWELL: dwell_ff <= csr_wdata[shsm_pkg::DWELL_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.steps_per_rev = spr_ff;
   assign cfg.dwell_ticks   = dwell_ff;

endmodule

`default_nettype wire

>>> src/shsm_core.sv
// ----------------------------------------------------------------------------
// shsm_core
// move state and next-state logic; steps are tracked as a remaining
// angle-times-revolution account that drops by one division per step
// ----------------------------------------------------------------------------
`default_nettype none

module shsm_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           fire,
   input  wire logic                           operation,
   input  wire logic [shsm_pkg::DEG_W-1:0]     degrees,
   input  wire shsm_pkg::cfg_type              cfg,
   output shsm_pkg::result_type                result
);

   logic [shsm_pkg::ACC_W-1:0]   acc_ff,    acc_in;
   logic [shsm_pkg::DWELL_W-1:0] dwell_ff,  dwell_in;
   logic [shsm_pkg::PHASE_W-1:0] phase_ff,  phase_in;
   logic                         rev_ff,    rev_in;
   logic [shsm_pkg::COIL_W-1:0]  coil_ff,   coil_in;
   logic                         moving_ff, moving_in;

   logic                         neg;
   logic [shsm_pkg::DEG_W-1:0]   mag;
   logic [shsm_pkg::PROD_W-1:0]  prod;
   logic [shsm_pkg::DWELL_W-1:0] dwell_next;
   logic                         rej;

   // magnitude of the angle and its product with steps per revolution
   assign neg  = degrees[shsm_pkg::DEG_W-1];
   assign mag  = neg ? (~degrees + shsm_pkg::DEG_W'(1)) : degrees;
   assign prod = shsm_pkg::PROD_W'(mag) * shsm_pkg::PROD_W'(cfg.steps_per_rev);
   assign dwell_next = dwell_ff + shsm_pkg::DWELL_W'(1);

   // next state for the item in hand
   always_comb begin
      acc_in    = acc_ff;
      dwell_in  = dwell_ff;
      phase_in  = phase_ff;
      rev_in    = rev_ff;
      coil_in   = coil_ff;
      moving_in = moving_ff;
      rej       = 1'b0;
      if (fire) begin
         if (operation == shsm_pkg::OP_MOVE) begin
            if (moving_ff) begin
               rej = 1'b1;
            end else begin
               dwell_in = '0;
               if (prod < shsm_pkg::PROD_ONE_STEP) begin
                  acc_in    = '0;
                  coil_in   = shsm_pkg::COILS_OFF;
                  moving_in = 1'b0;
               end else begin
                  acc_in    = (prod >= shsm_pkg::PROD_SAT_AT) ? shsm_pkg::ACC_SAT
                                                              : prod[shsm_pkg::ACC_W-1:0];
                  rev_in    = neg;
                  phase_in  = neg ? shsm_pkg::PHASE_REV_START : shsm_pkg::PHASE_FWD_START;
                  coil_in   = shsm_pkg::coil_of_phase(phase_in);
                  moving_in = 1'b1;
               end
            end
         end else if (moving_ff) begin
            if (dwell_next == cfg.dwell_ticks) begin
               dwell_in = '0;
               if (acc_ff < shsm_pkg::ACC_TWO_STEPS) begin
                  // last step's dwell is over
                  acc_in    = '0;
                  coil_in   = shsm_pkg::COILS_OFF;
                  moving_in = 1'b0;
               end else begin
                  acc_in   = acc_ff - shsm_pkg::ACC_ONE_STEP;
                  phase_in = rev_ff ? (phase_ff - shsm_pkg::PHASE_W'(1))
                                    : (phase_ff + shsm_pkg::PHASE_W'(1));
                  coil_in  = shsm_pkg::coil_of_phase(phase_in);
               end
            end else begin
               dwell_in = dwell_next;
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         dwell_ff  <= '0;
         phase_ff  <= '0;
         rev_ff    <= 1'b0;
         coil_ff   <= shsm_pkg::COILS_OFF;
         moving_ff <= 1'b0;
      end else begin
         acc_ff    <= acc_in;
         dwell_ff  <= dwell_in;
         phase_ff  <= phase_in;
         rev_ff    <= rev_in;
         coil_ff   <= coil_in;
         moving_ff <= moving_in;
      end
   end

   assign result.coil_drive = coil_in;
   assign result.busy       = moving_in;
   assign result.rejected   = rej;

endmodule

`default_nettype wire

>>> src/stepper_half_step_move.sv
// ----------------------------------------------------------------------------
// stepper_half_step_move: four-coil half-step move sequencer
// path: an accepted beat passes the input register, then the move logic
// into the result register; the only loop is the registered state update
// throughput: one item per cycle while rsp_stall does not hold the result
// reset: synchronous, active high; idle, coils off, registers to 400 and 625
// ----------------------------------------------------------------------------
`default_nettype none
`include "stepper_half_step_move_macros.svh"

module stepper_half_step_move (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // move and tick beats
   input  wire logic                             req_valid,
   output      logic                             req_stall,
   input  wire logic                             req_operation,
   input  wire logic signed [shsm_pkg::DEG_W-1:0] req_degrees,
   // result beats
   output      logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   output      logic [shsm_pkg::COIL_W-1:0]      rsp_coil_drive,
   output      logic                             rsp_busy_res,
   output      logic                             rsp_rejected,
   // configuration writes
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [shsm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [shsm_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   shsm_pkg::cfg_type    cfg;
   shsm_pkg::result_type result;

   logic                        in_valid_ff, in_valid_in;
   logic                        in_op_ff;
   logic [shsm_pkg::DEG_W-1:0]  in_deg_ff;
   logic                        out_valid_ff, out_valid_in;
   shsm_pkg::result_type        out_ff;
   logic                        out_free;
   logic                        fire;
   logic                        req_take;

   assign csr_ready = 1'b1;

   shsm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // pipeline flow control
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && !out_free);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff  <= req_operation;
         in_deg_ff <= req_degrees;
      end
   end

   shsm_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .operation (in_op_ff),
      .degrees   (in_deg_ff),
      .cfg       (cfg),
      .result    (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= result;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_coil_drive = out_ff.coil_drive;
   assign rsp_busy_res   = out_ff.busy;
   assign rsp_rejected   = out_ff.rejected;

   // checks
   `SHSM_ASSERT_IMPLIES(a_rej_busy, clock, reset, rsp_valid && rsp_rejected, rsp_busy_res, "rejected move without busy")
   `SHSM_ASSERT_IMPLIES(a_idle_off, clock, reset, rsp_valid && !rsp_busy_res, rsp_coil_drive == 4'h0, "coils on while idle")
   `SHSM_ASSERT_IMPLIES(a_busy_coils, clock, reset, rsp_valid && rsp_busy_res, $countones(rsp_coil_drive) == 1 || $countones(rsp_coil_drive) == 2, "bad half-step coil pattern")
   `SHSM_ASSERT_NEXT(a_stall_keeps, clock, reset, in_valid_ff && !out_free, in_valid_ff, "held beat lost")

endmodule

`default_nettype wire
